### sv/fenp_pkg.sv
// Shared types, codes and character constants for the FEN position parser.
package fenp_pkg;

	localparam int BOARD_FILES      = 8;
	localparam int COUNTER_BITS_DEF = 16;
	localparam int OUT_CNT_W        = 16;

	// ASCII characters the parser looks for
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LH    = 8'h68;
	localparam logic [7:0] CH_LW    = 8'h77;
	localparam logic [7:0] CH_LB    = 8'h62;

	typedef enum logic [2:0] {
		PH_PLACE  = 3'd0,
		PH_SIDE   = 3'd1,
		PH_CASTLE = 3'd2,
		PH_EP     = 3'd3,
		PH_HALF   = 3'd4,
		PH_FULL   = 3'd5
	} fenp_phase_t;

	typedef enum logic [3:0] {
		ERR_NONE      = 4'd0,
		ERR_MANY_FILE = 4'd1,
		ERR_MISS_RANK = 4'd2,
		ERR_MISS_FILE = 4'd3,
		ERR_MANY_RANK = 4'd4,
		ERR_TWO_DIGIT = 4'd5,
		ERR_PIECE     = 4'd6,
		ERR_END       = 4'd7,
		ERR_SIDE      = 4'd8,
		ERR_CASTLE    = 4'd9,
		ERR_EP        = 4'd10,
		ERR_HALF      = 4'd11,
		ERR_FULL      = 4'd12
	} fenp_err_t;

	// castling order tracker: 0 nothing yet, 1..4 next allowed letter
	localparam logic [2:0] CO_NONE    = 3'd0;
	localparam logic [2:0] CO_DASH    = 3'd5;
	localparam logic [2:0] CO_INVALID = 3'd6;

	// en passant field steps
	localparam logic [1:0] EP_FILE = 2'd0;
	localparam logic [1:0] EP_RANK = 2'd1;

	typedef struct packed {
		fenp_phase_t phase;
		logic [3:0]  rank;
		logic [4:0]  file;
		logic        digit_last;
		logic [1:0]  sub;
		logic        side;
		logic [3:0]  cmask;
		logic [2:0]  corder;
		logic [6:0]  ep;
		fenp_err_t   err;
	} fenp_ctl_t;

	typedef struct packed {
		logic        square_write;
		logic [5:0]  square_index;
		logic [3:0]  piece_code;
		logic        done_res;
		logic [3:0]  error_code;
		logic        black_to_move;
		logic [3:0]  castle_rights;
		logic        en_passant_valid;
		logic [5:0]  en_passant_square;
		logic [15:0] half_moves;
		logic [15:0] full_moves;
	} fenp_res_t;

	function automatic logic [3:0] piece_of(input logic [7:0] c);
		logic [3:0] p;
		unique case (c)
			8'h50: p = 4'd1;  // P
			8'h4E: p = 4'd2;  // N
			8'h42: p = 4'd3;  // B
			8'h52: p = 4'd4;  // R
			8'h51: p = 4'd5;  // Q
			8'h4B: p = 4'd6;  // K
			8'h70: p = 4'd7;  // p
			8'h6E: p = 4'd8;  // n
			8'h62: p = 4'd9;  // b
			8'h72: p = 4'd10; // r
			8'h71: p = 4'd11; // q
			8'h6B: p = 4'd12; // k
			default: p = 4'd0;
		endcase
		return p;
	endfunction

	// castling letter: {hit, index}, order K Q k q
	function automatic logic [2:0] castle_of(input logic [7:0] c);
		logic [2:0] r;
		unique case (c)
			8'h4B: r = 3'b100;
			8'h51: r = 3'b101;
			8'h6B: r = 3'b110;
			8'h71: r = 3'b111;
			default: r = 3'b000;
		endcase
		return r;
	endfunction

endpackage

### sv/fenp_char_if.sv
// Character input channel: valid/ready with one byte and an end flag.
interface fenp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       last_byte;

	modport source (output valid, output char_byte, output last_byte, input ready);
	modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

### sv/fenp_res_if.sv
// Result channel: valid/ready with square write and position summary fields.
interface fenp_res_if;
	logic        valid;
	logic        ready;
	logic        square_write;
	logic [5:0]  square_index;
	logic [3:0]  piece_code;
	logic        done_res;
	logic [3:0]  error_code;
	logic        black_to_move;
	logic [3:0]  castle_rights;
	logic        en_passant_valid;
	logic [5:0]  en_passant_square;
	logic [15:0] half_moves;
	logic [15:0] full_moves;

	modport source (output valid, input ready, output square_write, output square_index,
		output piece_code, output done_res, output error_code, output black_to_move,
		output castle_rights, output en_passant_valid, output en_passant_square,
		output half_moves, output full_moves);
	modport sink (input valid, output ready, input square_write, input square_index,
		input piece_code, input done_res, input error_code, input black_to_move,
		input castle_rights, input en_passant_valid, input en_passant_square,
		input half_moves, input full_moves);
endinterface

### sv/fen_position_parser.sv
// FEN position parser top level: input register, parse step, result register.
// Throughput: 1 character per cycle while the result register is not stalled;
// one result item per character, every time.
// The parse state is updated as an item moves from the input register to the
// result register; that single step is what sets the rate.
// Reset (arst_n low, asynchronous): both registers empty, parse state cleared.
module fen_position_parser #(
	parameter int COUNTER_BITS = fenp_pkg::COUNTER_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	fenp_char_if.sink    fen,
	fenp_res_if.source   res
);

	// input register
	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                last_s1;

	// result register
	logic                valid_s2;
	fenp_pkg::fenp_res_t res_s2;

	// parse state
	fenp_pkg::fenp_ctl_t ctl_q;
	logic [COUNTER_BITS-1:0] half_q;
	logic [COUNTER_BITS-1:0] full_q;

	fenp_pkg::fenp_ctl_t ctl_nx;
	logic [COUNTER_BITS-1:0] half_nx;
	logic [COUNTER_BITS-1:0] full_nx;
	fenp_pkg::fenp_res_t res_nx;

	logic adv;   // item in s1 moves into the result register

	// s1 moves on when the result register is empty or being drained
	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign fen.ready = !valid_s1 || adv;

	fenp_step #(
		.CNT_W (COUNTER_BITS)
	) u_step (
		.ctl       (ctl_q),
		.half      (half_q),
		.full      (full_q),
		.char_byte (char_s1),
		.last_byte (last_s1),
		.ctl_nx    (ctl_nx),
		.half_nx   (half_nx),
		.full_nx   (full_nx),
		.res       (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fen.ready) begin
			valid_s1 <= fen.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fen.ready && fen.valid) begin
			char_s1 <= fen.char_byte;
			last_s1 <= fen.last_byte;
		end
	end

	// parse state only advances with an item; end of string clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q  <= '0;
			half_q <= '0;
			full_q <= '0;
		end else if (adv) begin
			ctl_q  <= ctl_nx;
			half_q <= half_nx;
			full_q <= full_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nx;
		end
	end

	assign res.valid             = valid_s2;
	assign res.square_write      = res_s2.square_write;
	assign res.square_index      = res_s2.square_index;
	assign res.piece_code        = res_s2.piece_code;
	assign res.done_res          = res_s2.done_res;
	assign res.error_code        = res_s2.error_code;
	assign res.black_to_move     = res_s2.black_to_move;
	assign res.castle_rights     = res_s2.castle_rights;
	assign res.en_passant_valid  = res_s2.en_passant_valid;
	assign res.en_passant_square = res_s2.en_passant_square;
	assign res.half_moves        = res_s2.half_moves;
	assign res.full_moves        = res_s2.full_moves;

	// the end of a string leaves the parser in its reset state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> ctl_q == '0 && half_q == '0 && full_q == '0)
		else $error("parse state not cleared after final item");

	// input only stalls behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!fen.ready |-> valid_s1 && valid_s2 && !res.ready)
		else $error("input stalled without output back-pressure");

	// a square write always carries a piece
	a_write_piece: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.square_write |-> res_s2.piece_code != 4'd0)
		else $error("square write with no piece");

	// summary fields are zero unless the string parsed cleanly
	a_summary_gated: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (!res_s2.done_res || res_s2.error_code != fenp_pkg::ERR_NONE)
		|-> res_s2.half_moves == '0 && res_s2.castle_rights == '0)
		else $error("summary fields set on error or mid-string");

endmodule

### sv/fenp_step.sv
// Next-state and result logic for one FEN character.
module fenp_step #(
	parameter int CNT_W = fenp_pkg::COUNTER_BITS_DEF
) (
	input  fenp_pkg::fenp_ctl_t ctl,
	input  logic [CNT_W-1:0]    half,
	input  logic [CNT_W-1:0]    full,
	input  logic [7:0]          char_byte,
	input  logic                last_byte,
	output fenp_pkg::fenp_ctl_t ctl_nx,
	output logic [CNT_W-1:0]    half_nx,
	output logic [CNT_W-1:0]    full_nx,
	output fenp_pkg::fenp_res_t res
);

	localparam logic [4:0] FILES5 = 5'(fenp_pkg::BOARD_FILES);
	localparam logic [3:0] LAST_RANK = 4'(fenp_pkg::BOARD_FILES - 1);

	// v*10 + d, saturating at all ones
	function automatic logic [CNT_W-1:0] add_digit(input logic [CNT_W-1:0] v,
		input logic [3:0] d);
		logic [CNT_W+3:0] n;
		n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (CNT_W+4)'(d);
		return (n > {4'b0, {CNT_W{1'b1}}}) ? {CNT_W{1'b1}} : n[CNT_W-1:0];
	endfunction

	fenp_pkg::fenp_ctl_t   st;
	fenp_pkg::fenp_err_t   flag;
	fenp_pkg::fenp_err_t   fin;
	logic                  is_digit;
	logic [3:0]            dval;
	logic [3:0]            piece;
	logic [2:0]            cl;
	logic [4:0]            file_sum;
	logic                  wr;
	logic [5:0]            wr_idx;
	logic [CNT_W-1:0]      h;
	logic [CNT_W-1:0]      f;

	always_comb begin
		st       = ctl;
		h        = half;
		f        = full;
		flag     = fenp_pkg::ERR_NONE;
		is_digit = (char_byte >= fenp_pkg::CH_0) && (char_byte <= fenp_pkg::CH_9);
		dval     = 4'(char_byte - fenp_pkg::CH_0);
		piece    = fenp_pkg::piece_of(char_byte);
		cl       = fenp_pkg::castle_of(char_byte);
		file_sum = ctl.file + 5'(dval);
		wr       = 1'b0;
		wr_idx   = {~ctl.rank[2:0], ctl.file[2:0]};

		if (ctl.err == fenp_pkg::ERR_NONE) begin
			unique case (ctl.phase)
				fenp_pkg::PH_PLACE: begin
					if (char_byte == fenp_pkg::CH_SPACE) begin
						if (ctl.rank != LAST_RANK) flag = fenp_pkg::ERR_MISS_RANK;
						else if (ctl.file != FILES5) flag = fenp_pkg::ERR_MISS_FILE;
						else begin
							st.phase = fenp_pkg::PH_SIDE;
							st.sub   = 2'd0;
						end
					end else if (char_byte == fenp_pkg::CH_SLASH) begin
						if (ctl.file != FILES5) flag = fenp_pkg::ERR_MISS_FILE;
						else begin
							st.rank       = ctl.rank + 4'd1;
							st.file       = 5'd0;
							st.digit_last = 1'b0;
							if (ctl.rank >= LAST_RANK) flag = fenp_pkg::ERR_MANY_RANK;
						end
					end else if (is_digit) begin
						if (ctl.digit_last) flag = fenp_pkg::ERR_TWO_DIGIT;
						else begin
							st.digit_last = 1'b1;
							st.file       = file_sum;
							if (file_sum > FILES5) flag = fenp_pkg::ERR_MANY_FILE;
						end
					end else if (piece == 4'd0) begin
						flag = fenp_pkg::ERR_PIECE;
					end else begin
						wr            = (ctl.file < FILES5) && (ctl.rank <= LAST_RANK);
						st.file       = ctl.file + 5'd1;
						st.digit_last = 1'b0;
						if (ctl.file + 5'd1 > FILES5) flag = fenp_pkg::ERR_MANY_FILE;
					end
				end
				fenp_pkg::PH_SIDE: begin
					if (ctl.sub == 2'd0) begin
						if (char_byte == fenp_pkg::CH_LW || char_byte == fenp_pkg::CH_LB) begin
							st.side = (char_byte == fenp_pkg::CH_LB);
							st.sub  = 2'd1;
						end else flag = fenp_pkg::ERR_SIDE;
					end else if (char_byte == fenp_pkg::CH_SPACE) begin
						st.phase = fenp_pkg::PH_CASTLE;
						st.sub   = 2'd0;
					end else flag = fenp_pkg::ERR_SIDE;
				end
				fenp_pkg::PH_CASTLE: begin
					if (char_byte == fenp_pkg::CH_SPACE) begin
						if (ctl.corder == fenp_pkg::CO_NONE || ctl.corder == fenp_pkg::CO_INVALID)
							flag = fenp_pkg::ERR_CASTLE;
						else begin
							st.phase = fenp_pkg::PH_EP;
							st.sub   = 2'd0;
						end
					end else if (ctl.corder == fenp_pkg::CO_INVALID) begin
						st.corder = ctl.corder;
					end else if (char_byte == fenp_pkg::CH_DASH) begin
						st.corder = (ctl.corder == fenp_pkg::CO_NONE) ? fenp_pkg::CO_DASH
							: fenp_pkg::CO_INVALID;
					end else if (cl[2] && ctl.corder <= {1'b0, cl[1:0]}) begin
						st.cmask[cl[1:0]] = 1'b1;
						st.corder         = {1'b0, cl[1:0]} + 3'd1;
					end else begin
						st.corder = fenp_pkg::CO_INVALID;
					end
				end
				fenp_pkg::PH_EP: begin
					if (ctl.sub == fenp_pkg::EP_FILE) begin
						if (char_byte == fenp_pkg::CH_DASH) begin
							st.ep  = 7'd0;
							st.sub = 2'd2;
						end else if (char_byte >= fenp_pkg::CH_LA
							&& char_byte <= fenp_pkg::CH_LH) begin
							st.ep  = 7'(char_byte - fenp_pkg::CH_LA);
							st.sub = fenp_pkg::EP_RANK;
						end else flag = fenp_pkg::ERR_EP;
					end else if (ctl.sub == fenp_pkg::EP_RANK) begin
						if (char_byte != (ctl.side ? fenp_pkg::CH_3 : fenp_pkg::CH_6))
							flag = fenp_pkg::ERR_EP;
						else begin
							st.ep  = {1'b1, 3'(char_byte - fenp_pkg::CH_1), ctl.ep[2:0]};
							st.sub = 2'd2;
						end
					end else begin
						// separator after the square, taken unchecked
						st.phase = fenp_pkg::PH_HALF;
						st.sub   = 2'd0;
					end
				end
				fenp_pkg::PH_HALF: begin
					if (char_byte == fenp_pkg::CH_SPACE) begin
						if (ctl.sub == 2'd0) flag = fenp_pkg::ERR_HALF;
						else begin
							st.phase = fenp_pkg::PH_FULL;
							st.sub   = 2'd0;
						end
					end else if (is_digit) begin
						h      = add_digit(half, dval);
						st.sub = 2'd1;
					end else flag = fenp_pkg::ERR_HALF;
				end
				fenp_pkg::PH_FULL: begin
					if (is_digit) begin
						f      = add_digit(full, dval);
						st.sub = 2'd1;
					end else flag = fenp_pkg::ERR_FULL;
				end
				default: st.phase = ctl.phase;
			endcase
		end
		if (flag != fenp_pkg::ERR_NONE) st.err = flag;

		// error seen at end of string, by where parsing stopped
		unique case (st.phase)
			fenp_pkg::PH_SIDE: fin = (st.sub == 2'd0) ? fenp_pkg::ERR_END : fenp_pkg::ERR_SIDE;
			fenp_pkg::PH_EP:   fin = (st.sub == 2'd0) ? fenp_pkg::ERR_EP : fenp_pkg::ERR_END;
			fenp_pkg::PH_HALF: fin = (st.sub == 2'd0) ? fenp_pkg::ERR_END : fenp_pkg::ERR_HALF;
			fenp_pkg::PH_FULL: fin = (st.sub == 2'd0) ? fenp_pkg::ERR_END : fenp_pkg::ERR_NONE;
			default:           fin = fenp_pkg::ERR_END;
		endcase
		if (st.err != fenp_pkg::ERR_NONE) fin = st.err;

		res                   = '0;
		res.square_write      = wr;
		res.square_index      = wr ? wr_idx : 6'd0;
		res.piece_code        = wr ? piece : 4'd0;
		res.done_res          = last_byte;
		if (last_byte) begin
			res.error_code = fin;
			if (fin == fenp_pkg::ERR_NONE) begin
				res.black_to_move     = st.side;
				res.castle_rights     = st.cmask;
				res.en_passant_valid  = st.ep[6];
				res.en_passant_square = st.ep[5:0];
				res.half_moves        = fenp_pkg::OUT_CNT_W'(h);
				res.full_moves        = fenp_pkg::OUT_CNT_W'(f);
			end
		end

		if (last_byte) begin
			ctl_nx  = '0;
			half_nx = '0;
			full_nx = '0;
		end else begin
			ctl_nx  = st;
			half_nx = h;
			full_nx = f;
		end
	end

endmodule

### verif/fen_parse_checker.sv
// Checker for the FEN position parser: tracks the parse, predicts each result item, compares.
module fen_parse_checker (
	input  logic  clk,
	input  logic  arst_n,
	fenp_char_if  fen,
	fenp_res_if   res,
	output int    n_awaited,
	output int    fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CNT_MAX = (1 << fenp_pkg::COUNTER_BITS_DEF) - 1;

	// steps inside a field; the en passant field uses the package steps
	localparam logic [1:0] FIELD_START = 2'd0;
	localparam logic [1:0] FIELD_BODY  = 2'd1;
	localparam logic [1:0] EP_SKIP     = 2'd2;

	fenp_pkg::fenp_phase_t phase;
	logic [3:0]  rank_n;
	logic [4:0]  file_n;
	logic        digit_seen;
	logic [1:0]  sub_step;
	logic        black_side;
	logic [3:0]  rights;
	logic [2:0]  letter_order;
	logic [6:0]  ep_sq;
	int unsigned half_n;
	int unsigned full_n;
	fenp_pkg::fenp_err_t first_err;

	fenp_pkg::fenp_res_t awaited[$];
	int          mismatches;

	assign fail_count = mismatches;

	function automatic void clear_parse();
		phase        = fenp_pkg::PH_PLACE;
		rank_n       = '0;
		file_n       = '0;
		digit_seen   = 1'b0;
		sub_step     = FIELD_START;
		black_side   = 1'b0;
		rights       = '0;
		letter_order = fenp_pkg::CO_NONE;
		ep_sq        = '0;
		half_n       = 0;
		full_n       = 0;
		first_err    = fenp_pkg::ERR_NONE;
	endfunction

	// only the first error sticks
	function automatic void note_error(input fenp_pkg::fenp_err_t e);
		if (first_err == fenp_pkg::ERR_NONE) first_err = e;
	endfunction

	function automatic int unsigned push_digit(input int unsigned v, input logic [7:0] c);
		int unsigned n;
		n = v * 10 + int'(c - fenp_pkg::CH_0);
		return (n > CNT_MAX) ? CNT_MAX : n;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= fenp_pkg::CH_0 && c <= fenp_pkg::CH_9;
	endfunction

	function automatic logic [3:0] letter_piece(input logic [7:0] c);
		string letters = "PNBRQKpnbrqk";
		for (int i = 0; i < 12; i++)
			if (c == letters[i]) return 4'(i + 1);
		return 4'd0;
	endfunction

	function automatic void place_char(input logic [7:0] c, inout fenp_pkg::fenp_res_t r);
		logic [3:0] p;
		p = letter_piece(c);
		if (c == fenp_pkg::CH_SPACE) begin
			if (rank_n != fenp_pkg::BOARD_FILES - 1) note_error(fenp_pkg::ERR_MISS_RANK);
			else if (file_n != fenp_pkg::BOARD_FILES) note_error(fenp_pkg::ERR_MISS_FILE);
			else begin
				phase    = fenp_pkg::PH_SIDE;
				sub_step = FIELD_START;
			end
		end else if (c == fenp_pkg::CH_SLASH) begin
			if (file_n != fenp_pkg::BOARD_FILES) note_error(fenp_pkg::ERR_MISS_FILE);
			else begin
				rank_n     = rank_n + 4'd1;
				file_n     = '0;
				digit_seen = 1'b0;
				if (rank_n >= fenp_pkg::BOARD_FILES) note_error(fenp_pkg::ERR_MANY_RANK);
			end
		end else if (is_digit(c)) begin
			if (digit_seen) note_error(fenp_pkg::ERR_TWO_DIGIT);
			else begin
				digit_seen = 1'b1;
				file_n     = file_n + 5'(c - fenp_pkg::CH_0);
				if (file_n > fenp_pkg::BOARD_FILES) note_error(fenp_pkg::ERR_MANY_FILE);
			end
		end else if (p == 4'd0) begin
			note_error(fenp_pkg::ERR_PIECE);
		end else begin
			// a piece past the board edge writes nothing but still counts
			if (file_n < fenp_pkg::BOARD_FILES && rank_n < fenp_pkg::BOARD_FILES) begin
				r.square_write = 1'b1;
				r.square_index = 6'((fenp_pkg::BOARD_FILES - 1 - int'(rank_n))
					* fenp_pkg::BOARD_FILES + int'(file_n));
				r.piece_code   = p;
			end
			file_n     = file_n + 5'd1;
			digit_seen = 1'b0;
			if (file_n > fenp_pkg::BOARD_FILES) note_error(fenp_pkg::ERR_MANY_FILE);
		end
	endfunction

	function automatic void castle_char(input logic [7:0] c);
		string order_letters = "KQkq";
		int hit;
		hit = -1;
		for (int i = 0; i < 4; i++)
			if (c == order_letters[i]) hit = i;
		if (c == fenp_pkg::CH_SPACE) begin
			if (letter_order == fenp_pkg::CO_NONE || letter_order == fenp_pkg::CO_INVALID)
				note_error(fenp_pkg::ERR_CASTLE);
			else begin
				phase    = fenp_pkg::PH_EP;
				sub_step = fenp_pkg::EP_FILE;
			end
		end else if (letter_order == fenp_pkg::CO_INVALID) begin
			// bad text seen, wait for the closing space
		end else if (c == fenp_pkg::CH_DASH) begin
			letter_order = (letter_order == fenp_pkg::CO_NONE) ? fenp_pkg::CO_DASH
				: fenp_pkg::CO_INVALID;
		end else if (hit >= 0 && int'(letter_order) <= hit) begin
			rights[hit]  = 1'b1;
			letter_order = 3'(hit + 1);
		end else begin
			letter_order = fenp_pkg::CO_INVALID;
		end
	endfunction

	function automatic void ep_char(input logic [7:0] c);
		case (sub_step)
			fenp_pkg::EP_FILE: begin
				if (c == fenp_pkg::CH_DASH) begin
					ep_sq    = '0;
					sub_step = EP_SKIP;
				end else if (c >= fenp_pkg::CH_LA && c <= fenp_pkg::CH_LH) begin
					ep_sq    = 7'(c - fenp_pkg::CH_LA);
					sub_step = fenp_pkg::EP_RANK;
				end else begin
					note_error(fenp_pkg::ERR_EP);
				end
			end
			fenp_pkg::EP_RANK: begin
				if (c != (black_side ? fenp_pkg::CH_3 : fenp_pkg::CH_6))
					note_error(fenp_pkg::ERR_EP);
				else begin
					ep_sq    = {1'b1, 6'(int'(c - fenp_pkg::CH_1) * fenp_pkg::BOARD_FILES
						+ int'(ep_sq[2:0]))};
					sub_step = EP_SKIP;
				end
			end
			default: begin
				// the byte after the square passes unchecked
				phase    = fenp_pkg::PH_HALF;
				sub_step = FIELD_START;
			end
		endcase
	endfunction

	function automatic fenp_pkg::fenp_err_t closing_error();
		case (phase)
			fenp_pkg::PH_SIDE:
				return (sub_step == FIELD_START) ? fenp_pkg::ERR_END : fenp_pkg::ERR_SIDE;
			fenp_pkg::PH_EP:
				return (sub_step == fenp_pkg::EP_FILE) ? fenp_pkg::ERR_EP : fenp_pkg::ERR_END;
			fenp_pkg::PH_HALF:
				return (sub_step == FIELD_START) ? fenp_pkg::ERR_END : fenp_pkg::ERR_HALF;
			fenp_pkg::PH_FULL:
				return (sub_step == FIELD_START) ? fenp_pkg::ERR_END : fenp_pkg::ERR_NONE;
			default: return fenp_pkg::ERR_END;
		endcase
	endfunction

	function automatic fenp_pkg::fenp_res_t parse_char(input logic [7:0] c, input logic last);
		fenp_pkg::fenp_res_t r;
		r = '0;
		if (first_err == fenp_pkg::ERR_NONE) begin
			case (phase)
				fenp_pkg::PH_PLACE:  place_char(c, r);
				fenp_pkg::PH_SIDE: begin
					if (sub_step == FIELD_START) begin
						if (c == fenp_pkg::CH_LW || c == fenp_pkg::CH_LB) begin
							black_side = (c == fenp_pkg::CH_LB);
							sub_step   = FIELD_BODY;
						end else begin
							note_error(fenp_pkg::ERR_SIDE);
						end
					end else if (c == fenp_pkg::CH_SPACE) begin
						phase    = fenp_pkg::PH_CASTLE;
						sub_step = FIELD_START;
					end else begin
						note_error(fenp_pkg::ERR_SIDE);
					end
				end
				fenp_pkg::PH_CASTLE: castle_char(c);
				fenp_pkg::PH_EP:     ep_char(c);
				fenp_pkg::PH_HALF: begin
					if (c == fenp_pkg::CH_SPACE) begin
						if (sub_step == FIELD_START) note_error(fenp_pkg::ERR_HALF);
						else begin
							phase    = fenp_pkg::PH_FULL;
							sub_step = FIELD_START;
						end
					end else if (is_digit(c)) begin
						half_n   = push_digit(half_n, c);
						sub_step = FIELD_BODY;
					end else begin
						note_error(fenp_pkg::ERR_HALF);
					end
				end
				fenp_pkg::PH_FULL: begin
					if (is_digit(c)) begin
						full_n   = push_digit(full_n, c);
						sub_step = FIELD_BODY;
					end else begin
						note_error(fenp_pkg::ERR_FULL);
					end
				end
				default: begin
				end
			endcase
		end
		if (last) begin
			if (first_err == fenp_pkg::ERR_NONE) note_error(closing_error());
			r.done_res   = 1'b1;
			r.error_code = first_err;
			if (first_err == fenp_pkg::ERR_NONE) begin
				r.black_to_move     = black_side;
				r.castle_rights     = rights;
				r.en_passant_valid  = ep_sq[6];
				r.en_passant_square = ep_sq[5:0];
				r.half_moves        = 16'(half_n);
				r.full_moves        = 16'(full_n);
			end
			clear_parse();
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		fenp_pkg::fenp_res_t want;
		fenp_pkg::fenp_res_t got;
		if (!arst_n) begin
			clear_parse();
			awaited.delete();
			mismatches = 0;
			n_awaited <= 0;
		end else begin
			if (res.valid && res.ready) begin
				got.square_write      = res.square_write;
				got.square_index      = res.square_index;
				got.piece_code        = res.piece_code;
				got.done_res          = res.done_res;
				got.error_code        = res.error_code;
				got.black_to_move     = res.black_to_move;
				got.castle_rights     = res.castle_rights;
				got.en_passant_valid  = res.en_passant_valid;
				got.en_passant_square = res.en_passant_square;
				got.half_moves        = res.half_moves;
				got.full_moves        = res.full_moves;
				if (awaited.size() == 0) begin
					$error("result item with no expectation pending");
					mismatches++;
				end else begin
					want = awaited.pop_front();
					check_field("square_write", want.square_write, got.square_write);
					check_field("square_index", want.square_index, got.square_index);
					check_field("piece_code", want.piece_code, got.piece_code);
					check_field("done_res", want.done_res, got.done_res);
					check_field("error_code", want.error_code, got.error_code);
					check_field("black_to_move", want.black_to_move, got.black_to_move);
					check_field("castle_rights", want.castle_rights,
						got.castle_rights);
					check_field("en_passant_valid", want.en_passant_valid,
						got.en_passant_valid);
					check_field("en_passant_square", want.en_passant_square,
						got.en_passant_square);
					check_field("half_moves", want.half_moves, got.half_moves);
					check_field("full_moves", want.full_moves, got.full_moves);
				end
			end
			if (fen.valid && fen.ready)
				awaited.push_back(parse_char(fen.char_byte, fen.last_byte));
			n_awaited <= awaited.size();
		end
	end

endmodule

### verif/testbench.sv
// Testbench top for the FEN position parser: clock, reset, FEN string stimulus, verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// directed strings take 24 items, the random strings the rest; the last
	// random string runs a little past the target
	localparam int ITEM_TARGET = 24 + 900;
	// well above what the slowest run needs; this leaves a wide margin
	localparam int CYCLE_LIMIT = 200000;
	// items per idling phase before moving to the next one
	localparam int PHASE_ITEMS = 150;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic       clk;
	logic       arst_n;
	int         n_awaited;
	int         fail_count;
	int         sent_n;
	int         cycles;
	idle_mode_t idle_mode;

	// bytes of the string being built, sent front to back
	logic [7:0] fen_text[$];

	fenp_char_if fen_bus();
	fenp_res_if  res_bus();

	fen_position_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.fen    (fen_bus),
		.res    (res_bus)
	);

	fen_parse_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.fen        (fen_bus),
		.res        (res_bus),
		.n_awaited  (n_awaited),
		.fail_count (fail_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// receiver: stalls heavily in its own phase, lightly when both sides idle
	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECV: res_bus.ready <= !roll(56);
			IDLE_BOTH: res_bus.ready <= !roll(6);
			default:   res_bus.ready <= 1'b1;
		endcase
	end

	// watchdog: a hung handshake or a lost result item ends up here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one item: optional idle cycles, then hold valid until ready
	task automatic send_char(input logic [7:0] c, input logic last);
		while ((idle_mode == IDLE_SEND && roll(56)) || (idle_mode == IDLE_BOTH && roll(6)))
		begin
			fen_bus.valid     <= 1'b0;
			fen_bus.char_byte <= 8'($urandom_range(255));
			@(posedge clk);
		end
		fen_bus.valid     <= 1'b1;
		fen_bus.char_byte <= c;
		fen_bus.last_byte <= last;
		do @(posedge clk); while (!fen_bus.ready);
		sent_n++;
		// switch idling phase every so many items, so gaps land everywhere
		idle_mode <= idle_mode_t'((sent_n / PHASE_ITEMS) % 4);
	endtask

	// send the first n bytes of the string, flagging the last one
	task automatic send_fen(input int n);
		for (int i = 0; i < n; i++)
			send_char(fen_text[i], i == n - 1);
		fen_text.delete();
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			fen_text.push_back(s[i]);
	endtask

	// halfmove/fullmove digits: mostly short, now and then long enough to saturate
	function automatic int counter_len();
		int r;
		r = $urandom_range(9);
		if (r < 7) return $urandom_range(2, 1);
		if (r < 9) return $urandom_range(4, 3);
		return $urandom_range(7, 5);
	endfunction

	// Build one FEN string, corrupt it now and then, and send it.
	// About half the strings go through clean, so every field gets real content;
	// the rest carry a bad byte, a dropped byte or an early end.
	task automatic build_and_send();
		string pieces = "PNBRQKpnbrqk";
		string castle_letters = "KQkq";
		string castle_noise = "KQkq-";
		string pool = "/ 0123456789PNBRQKpnbrqkwb-aeh";
		int    density;
		int    left;
		int    n;
		int    cut;
		bit    was_digit;
		bit    black;
		logic [3:0] mask;

		// short garbage strings: errors in the first field, any byte value
		if (roll(15)) begin
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++)
				fen_text.push_back(roll(50) ? 8'($urandom_range(255))
					: pool[$urandom_range(pool.len() - 1)]);
			send_fen(n);
			return;
		end

		// placement: eight ranks, files summing to eight, no two digits in a row;
		// density sets how often empty runs show up, which keeps strings short
		density = $urandom_range(9, 1);
		for (int rk = 0; rk < fenp_pkg::BOARD_FILES; rk++) begin
			left      = fenp_pkg::BOARD_FILES;
			was_digit = 1'b0;
			while (left > 0) begin
				if (!was_digit && $urandom_range(9) < density) begin
					n = $urandom_range(left, 1);
					fen_text.push_back(8'(fenp_pkg::CH_0 + n));
					left -= n;
					was_digit = 1'b1;
				end else begin
					fen_text.push_back(pieces[$urandom_range(11)]);
					left--;
					was_digit = 1'b0;
					// a zero is a digit that adds no files
					if (roll(5)) begin
						fen_text.push_back(fenp_pkg::CH_0);
						was_digit = 1'b1;
					end
				end
			end
			if (rk < fenp_pkg::BOARD_FILES - 1) fen_text.push_back(fenp_pkg::CH_SLASH);
		end

		// side to move
		black = roll(50);
		fen_text.push_back(fenp_pkg::CH_SPACE);
		fen_text.push_back(black ? fenp_pkg::CH_LB : fenp_pkg::CH_LW);
		fen_text.push_back(fenp_pkg::CH_SPACE);

		// castling: dash, an ordered subset, or a random mix that is often out of order
		if (roll(20)) begin
			fen_text.push_back(fenp_pkg::CH_DASH);
		end else if (roll(65)) begin
			mask = 4'($urandom_range(15, 1));
			for (int i = 0; i < 4; i++)
				if (mask[i]) fen_text.push_back(castle_letters[i]);
		end else begin
			n = $urandom_range(4, 1);
			for (int i = 0; i < n; i++)
				fen_text.push_back(castle_noise[$urandom_range(4)]);
		end
		fen_text.push_back(fenp_pkg::CH_SPACE);

		// en passant: dash or a square, mostly on the rank that fits the side to move
		if (roll(50)) begin
			fen_text.push_back(fenp_pkg::CH_DASH);
		end else begin
			fen_text.push_back(8'(fenp_pkg::CH_LA + $urandom_range(7)));
			if (roll(10)) fen_text.push_back(8'(fenp_pkg::CH_1 + $urandom_range(8)));
			else fen_text.push_back(black ? fenp_pkg::CH_3 : fenp_pkg::CH_6);
		end
		// this byte is skipped by the parser, so odd values here go unnoticed
		fen_text.push_back(roll(90) ? fenp_pkg::CH_SPACE : 8'($urandom_range(255)));

		// the two move counters
		n = counter_len();
		for (int i = 0; i < n; i++)
			fen_text.push_back(8'(fenp_pkg::CH_0 + $urandom_range(9)));
		fen_text.push_back(fenp_pkg::CH_SPACE);
		n = counter_len();
		for (int i = 0; i < n; i++)
			fen_text.push_back(8'(fenp_pkg::CH_0 + $urandom_range(9)));

		// corruption
		cut = 0;
		case ($urandom_range(9))
			0: fen_text[$urandom_range(fen_text.size() - 1)] = 8'($urandom_range(255));
			1: fen_text[$urandom_range(fen_text.size() - 1)] =
				pool[$urandom_range(pool.len() - 1)];
			2: fen_text.delete($urandom_range(fen_text.size() - 1));
			3: cut = $urandom_range(fen_text.size() - 1, 1);
			default: begin
			end
		endcase
		send_fen(cut != 0 ? cut : fen_text.size());
	endtask

	initial begin
		// known values from time zero, with reset held asserted at the start
		arst_n            = 1'b0;
		fen_bus.valid     = 1'b0;
		fen_bus.char_byte = '0;
		fen_bus.last_byte = 1'b0;
		res_bus.ready     = 1'b0;
		idle_mode         = IDLE_NONE;
		sent_n            = 0;
		cycles            = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extreme bytes, both flagged as last -> bad piece
		fen_text.push_back(8'hFF);
		send_fen(1);
		fen_text.push_back(8'h00);
		send_fen(1);
		// a nine overruns the rank
		queue_text("9");
		send_fen(fen_text.size());
		// two digits in a row
		queue_text("00");
		send_fen(fen_text.size());
		// rank closed early
		queue_text("/");
		send_fen(fen_text.size());
		// string ends inside the placement field
		queue_text("K");
		send_fen(fen_text.size());
		// space before all ranks are given
		queue_text(" ");
		send_fen(fen_text.size());
		// a ninth rank
		queue_text("8/8/8/8/8/8/8/8/");
		send_fen(fen_text.size());

		// random strings
		while (sent_n < ITEM_TARGET)
			build_and_send();
		fen_bus.valid <= 1'b0;

		// drain: wait for every expected result, then keep watching for strays
		do @(posedge clk); while (n_awaited != 0);
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
